// ----- rtl/nopq_pkg.sv -----
// Shared types, constants and helpers for the note-off priority message queue.
// No dependencies; the cell, top level and testbench refer to this package by scoped names.
`default_nettype none

package nopq_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH  = 32;
    localparam int DRAIN_BUDGET = 8;

    // Status byte class test
    localparam logic [7:0] KIND_MASK     = 8'hF0;
    localparam logic [7:0] NOTE_OFF_KIND = 8'h80;

    // Command codes
    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_FLUSH
    } t_state;

    // One stored message
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] data_one;
        logic [7:0] data_two;
    } t_entry;

    // One result word
    typedef struct packed {
        logic   accepted;
        logic   message_valid;
        t_entry msg;
        logic   last_of_run;
    } t_result;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift;     // take the neighbor's entry
        logic load;      // the tail cell loads a new entry
        logic load_head; // load source: 1 = recirculated head, 0 = pushed word
    } t_cell_ctrl;

    function automatic logic is_note_off(input logic [7:0] status);
        return (status & KIND_MASK) == NOTE_OFF_KIND;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nopq_if.sv -----
// Valid/ready channel interfaces for the command and result words.
// Does not depend on nopq_pkg; payload fields are plain vectors.
`default_nettype none

interface nopq_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;

    modport source (output valid, output operation, output status_byte,
                    output data_one, output data_two, input ready);
    modport sink   (input valid, input operation, input status_byte,
                    input data_one, input data_two, output ready);
endinterface

interface nopq_res_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       message_valid;
    logic [7:0] out_status;
    logic [7:0] out_data_one;
    logic [7:0] out_data_two;
    logic       last_of_run;

    modport source (output valid, output accepted, output message_valid,
                    output out_status, output out_data_one, output out_data_two,
                    output last_of_run, input ready);
    modport sink   (input valid, input accepted, input message_valid,
                    input out_status, input out_data_one, input out_data_two,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/nopq_cell.sv -----
// One queue cell: holds a single message and passes it toward the head.
// Depends on nopq_pkg for t_entry and t_cell_ctrl.
`default_nettype none

module nopq_cell #(
    parameter int DEPTH = nopq_pkg::QUEUE_DEPTH,
    parameter int INDEX = 0
) (
    input  wire logic                      i_clk,
    input  wire nopq_pkg::t_cell_ctrl      i_ctrl,
    input  wire logic [$clog2(DEPTH)-1:0]  i_tail,
    input  wire nopq_pkg::t_entry          i_next,
    input  wire nopq_pkg::t_entry          i_head,
    input  wire nopq_pkg::t_entry          i_push,
    output nopq_pkg::t_entry               o_entry
);

    localparam int IDX_W = $clog2(DEPTH);

    nopq_pkg::t_entry r_entry;
    logic             w_is_tail;

    assign w_is_tail = (i_tail == IDX_W'(INDEX));

    // Load at the tail, otherwise advance from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && w_is_tail) begin
            r_entry <= i_ctrl.load_head ? i_head : i_push;
        end else if (i_ctrl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ----- rtl/note_off_priority_message_queue.sv -----
// Top level: controller plus a chain of message cells, oldest message in cell 0.
// Depends on nopq_pkg, nopq_if (nopq_cmd_if, nopq_res_if) and nopq_cell.
//
//   channel  dir  word                                            accepted when
//   i_cmd    in   operation, status_byte, data_one, data_two      valid && ready
//   o_res    out  accepted, message_valid, out_status,            valid && ready
//                 out_data_one, out_data_two, last_of_run
//
// A push gives one result word. A drain rotates the chain one cell per cycle while
// the output register is free: a note-off pass over all N stored messages, then,
// if messages and budget remain, a pass over the messages left, then a flush
// state to release the final word.
// Reset is synchronous, active low, and empties the queue; cell contents are not cleared.
// A full output register stalls the rotation; commands are taken only when idle.
`default_nettype none

module note_off_priority_message_queue #(
    parameter int QUEUE_DEPTH  = nopq_pkg::QUEUE_DEPTH,
    parameter int DRAIN_BUDGET = nopq_pkg::DRAIN_BUDGET
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    nopq_cmd_if.sink    i_cmd,
    nopq_res_if.source  o_res
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LEFT_W = $clog2(DRAIN_BUDGET + 1);

    nopq_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_steps, n_steps;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic                 r_pend_valid, n_pend_valid;
    nopq_pkg::t_entry     r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    nopq_pkg::t_result    r_out, n_out;

    nopq_pkg::t_cell_ctrl w_ctrl;
    logic [IDX_W-1:0]     w_tail;
    nopq_pkg::t_entry     w_chain [QUEUE_DEPTH+1];
    nopq_pkg::t_entry     w_head;
    nopq_pkg::t_entry     w_push;
    logic                 w_out_free;
    logic                 w_take;
    logic [CNT_W-1:0]     w_rem;
    logic [LEFT_W-1:0]    w_left_nx;

    // Cell chain
    assign w_chain[QUEUE_DEPTH] = '0;
    assign w_head = w_chain[0];
    assign w_push = '{status: i_cmd.status_byte, data_one: i_cmd.data_one,
                      data_two: i_cmd.data_two};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        nopq_cell #(
            .DEPTH (QUEUE_DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_tail  (w_tail),
            .i_next  (w_chain[g+1]),
            .i_head  (w_head),
            .i_push  (w_push),
            .o_entry (w_chain[g])
        );
    end

    assign w_out_free = !r_out_valid || o_res.ready;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nopq_pkg::ST_IDLE;
            r_count      <= '0;
            r_steps      <= '0;
            r_left       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_steps      <= n_steps;
            r_left       <= n_left;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // Next state, cell commands and result words
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_steps      = r_steps;
        n_left       = r_left;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out        = r_out;
        w_ctrl       = '0;
        w_tail       = '0;
        w_take       = 1'b0;
        w_rem        = r_count;
        w_left_nx    = r_left;
        i_cmd.ready  = 1'b0;

        case (r_state)
            nopq_pkg::ST_IDLE: begin
                i_cmd.ready = w_out_free;
                if (i_cmd.valid && w_out_free) begin
                    if (i_cmd.operation == nopq_pkg::OP_PUSH) begin
                        // Store at the tail if there is room
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.last_of_run = 1'b1;
                        if (r_count != CNT_W'(QUEUE_DEPTH)) begin
                            n_out.accepted = 1'b1;
                            w_ctrl.load    = 1'b1;
                            w_tail         = r_count[IDX_W-1:0];
                            n_count        = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        // Empty drain gives one blank word
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.last_of_run = 1'b1;
                    end else begin
                        n_state      = nopq_pkg::ST_SCAN;
                        n_steps      = r_count;
                        n_left       = LEFT_W'(DRAIN_BUDGET);
                        n_pend_valid = 1'b0;
                    end
                end
            end

            nopq_pkg::ST_SCAN, nopq_pkg::ST_FILL: begin
                if (w_out_free) begin
                    w_take = (r_left != '0) &&
                             (nopq_pkg::is_note_off(w_head.status) ==
                              (r_state == nopq_pkg::ST_SCAN));
                    w_ctrl.shift = 1'b1;
                    if (w_take) begin
                        // Drop the head; release the word held before it
                        w_rem        = r_count - CNT_W'(1);
                        w_left_nx    = r_left - LEFT_W'(1);
                        n_count      = w_rem;
                        n_left       = w_left_nx;
                        n_pend       = w_head;
                        n_pend_valid = 1'b1;
                        if (r_pend_valid) begin
                            n_out_valid         = 1'b1;
                            n_out               = '0;
                            n_out.message_valid = 1'b1;
                            n_out.msg           = r_pend;
                        end
                    end else begin
                        // Recirculate the head to the tail
                        w_ctrl.load      = 1'b1;
                        w_ctrl.load_head = 1'b1;
                        w_tail           = IDX_W'(r_count - CNT_W'(1));
                    end
                    n_steps = r_steps - CNT_W'(1);
                    if (r_steps == CNT_W'(1)) begin
                        if (r_state == nopq_pkg::ST_SCAN && w_rem != '0 &&
                            w_left_nx != '0) begin
                            n_state = nopq_pkg::ST_FILL;
                            n_steps = w_rem;
                        end else begin
                            n_state = nopq_pkg::ST_FLUSH;
                        end
                    end
                end
            end

            nopq_pkg::ST_FLUSH: begin
                // Release the final word of the run
                if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out               = '0;
                    n_out.message_valid = 1'b1;
                    n_out.msg           = r_pend;
                    n_out.last_of_run   = 1'b1;
                    n_pend_valid        = 1'b0;
                    n_state             = nopq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = nopq_pkg::ST_IDLE;
            end
        endcase
    end

    // Result port
    assign o_res.valid         = r_out_valid;
    assign o_res.accepted      = r_out.accepted;
    assign o_res.message_valid = r_out.message_valid;
    assign o_res.out_status    = r_out.msg.status;
    assign o_res.out_data_one  = r_out.msg.data_one;
    assign o_res.out_data_two  = r_out.msg.data_two;
    assign o_res.last_of_run   = r_out.last_of_run;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == nopq_pkg::ST_IDLE |-> !r_pend_valid)
        else $error("held word left over after a drain");

    a_drain_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nopq_pkg::ST_SCAN || r_state == nopq_pkg::ST_FILL)
        |=> r_count <= $past(r_count))
        else $error("fill count grew during a drain");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nopq_pkg::ST_SCAN || r_state == nopq_pkg::ST_FILL)
        |-> (r_steps != '0 && r_steps <= r_count))
        else $error("rotation step count out of range");

    a_flush_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == nopq_pkg::ST_FLUSH |-> r_pend_valid)
        else $error("drain ended with no word taken");
`endif

endmodule

`default_nettype wire

// ----- tb/note_off_priority_message_queue_tb.sv -----
// Self-checking testbench for the note-off priority message queue.
// Uses nopq_pkg for types and sizes, nopq_if for the channels, and drives the top level.
module note_off_priority_message_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_SETTLE    = 2 * nopq_pkg::QUEUE_DEPTH + 4;

    // Track the queue contents and the result words they imply
    class priority_queue_scoreboard;
        nopq_pkg::t_entry  held_msgs[$];
        nopq_pkg::t_result expected_words[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        // Predict the result words for one accepted command word
        function void note_command(nopq_pkg::t_op op, nopq_pkg::t_entry msg);
            nopq_pkg::t_result word;
            nopq_pkg::t_entry  picked[$];
            nopq_pkg::t_entry  kept[$];
            bit                taken[$];
            word = '0;
            if (op == nopq_pkg::OP_PUSH) begin
                word.last_of_run = 1'b1;
                if (held_msgs.size() < nopq_pkg::QUEUE_DEPTH) begin
                    held_msgs.push_back(msg);
                    word.accepted = 1'b1;
                end
                expected_words.push_back(word);
            end else if (held_msgs.size() == 0) begin
                word.last_of_run = 1'b1;
                expected_words.push_back(word);
            end else begin
                foreach (held_msgs[i]) taken.push_back(1'b0);
                // Take note-offs first, then fill the budget with the rest, oldest first
                for (int pass = 0; pass < 2; pass++) begin
                    foreach (held_msgs[i]) begin
                        if (picked.size() < nopq_pkg::DRAIN_BUDGET && !taken[i] &&
                            (((held_msgs[i].status & nopq_pkg::KIND_MASK) ==
                              nopq_pkg::NOTE_OFF_KIND) == (pass == 0))) begin
                            taken[i] = 1'b1;
                            picked.push_back(held_msgs[i]);
                        end
                    end
                end
                // Keep the leftovers in their original order
                foreach (held_msgs[i]) begin
                    if (!taken[i]) kept.push_back(held_msgs[i]);
                end
                held_msgs = kept;
                foreach (picked[k]) begin
                    word = '0;
                    word.message_valid = 1'b1;
                    word.msg = picked[k];
                    word.last_of_run = (k == picked.size() - 1);
                    expected_words.push_back(word);
                end
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one result word against the oldest prediction
        function void check_word(nopq_pkg::t_result got);
            nopq_pkg::t_result want;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: 0x%h", got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
            compare_field("message_valid", 8'(want.message_valid), 8'(got.message_valid));
            compare_field("out_status", want.msg.status, got.msg.status);
            compare_field("out_data_one", want.msg.data_one, got.msg.data_one);
            compare_field("out_data_two", want.msg.data_two, got.msg.data_two);
            compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_request;

    priority_queue_scoreboard board;

    nopq_cmd_if cmd_bus ();
    nopq_res_if res_bus ();

    note_off_priority_message_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Draw a message, half of them forced into the note-off class
    function automatic nopq_pkg::t_entry random_message();
        nopq_pkg::t_entry m;
        if ($urandom_range(0, 1) != 0)
            m.status = nopq_pkg::NOTE_OFF_KIND | 8'($urandom_range(0, 15));
        else
            m.status = 8'($urandom_range(0, 255));
        m.data_one = 8'($urandom_range(0, 255));
        m.data_two = 8'($urandom_range(0, 255));
        return m;
    endfunction

    // Offer one command word, with a random gap ahead of it
    task automatic send_command(nopq_pkg::t_op op, nopq_pkg::t_entry msg);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.operation   <= op;
        cmd_bus.status_byte <= msg.status;
        cmd_bus.data_one    <= msg.data_one;
        cmd_bus.data_two    <= msg.data_two;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        board.note_command(op, msg);
    endtask

    // Alternate push bursts, some long enough to fill the queue, with short drain bursts
    task automatic run_random_traffic(int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if (sent < n_items) begin
                    send_command(nopq_pkg::OP_PUSH, random_message());
                    sent++;
                end
            end
            burst = $urandom_range(1, 4);
            repeat (burst) begin
                if (sent < n_items) begin
                    send_command(nopq_pkg::OP_DRAIN, random_message());
                    sent++;
                end
            end
        end
    endtask

    // Take result words, check them, and throttle ready
    initial begin : result_sink
        int                hold_left;
        bit                hold_taken;
        nopq_pkg::t_result got;
        hold_left     = 0;
        hold_taken    = 1'b0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready) begin
                got.accepted      = res_bus.accepted;
                got.message_valid = res_bus.message_valid;
                got.msg.status    = res_bus.out_status;
                got.msg.data_one  = res_bus.out_data_one;
                got.msg.data_two  = res_bus.out_data_two;
                got.last_of_run   = res_bus.last_of_run;
                board.check_word(got);
            end
            if (!hold_taken && hold_request > 0) begin
                hold_left  = hold_request;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // End the run if neither channel moves a word for too long
    initial begin : stall_watch
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("note_off_priority_message_queue_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        board               = new();
        i_rst_n             = 1'b0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.operation   = nopq_pkg::OP_PUSH;
        cmd_bus.status_byte = 8'h00;
        cmd_bus.data_one    = 8'h00;
        cmd_bus.data_two    = 8'h00;
        send_idle_pct       = 30;
        recv_idle_pct       = 88;
        hold_request        = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Drain on an empty queue
        send_command(nopq_pkg::OP_DRAIN, nopq_pkg::t_entry'{8'h00, 8'h00, 8'h00});
        // Field extremes and class boundaries of the status byte
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h80, 8'h00, 8'h00});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'hFF, 8'hFF, 8'hFF});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h00, 8'h00, 8'h00});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h8F, 8'h7F, 8'h01});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h7F, 8'h80, 8'hFE});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h90, 8'h3C, 8'h40});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h81, 8'h55, 8'hAA});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h9F, 8'hAA, 8'h55});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h8A, 8'h12, 8'h34});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h70, 8'h56, 8'h78});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'h88, 8'h9A, 8'hBC});
        send_command(nopq_pkg::OP_PUSH, nopq_pkg::t_entry'{8'hE0, 8'hDE, 8'hF0});
        // Drain over budget, then the remainder, then empty again
        send_command(nopq_pkg::OP_DRAIN, nopq_pkg::t_entry'{8'hFF, 8'hFF, 8'hFF});
        send_command(nopq_pkg::OP_DRAIN, nopq_pkg::t_entry'{8'h00, 8'h00, 8'h00});
        send_command(nopq_pkg::OP_DRAIN, nopq_pkg::t_entry'{8'h80, 8'h80, 8'h80});

        run_random_traffic(110);

        send_idle_pct = 88;
        recv_idle_pct = 30;
        run_random_traffic(110);

        // No idling; hold the receiver off so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_OFF_CYCLES;
        run_random_traffic(115);

        cmd_bus.valid <= 1'b0;
        while (board.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);

        if (board.errors == 0)
            $display("note_off_priority_message_queue_tb: done, clean");
        else
            $display("note_off_priority_message_queue_tb: done, errors");
        $finish;
    end

endmodule
